// ----- rtl/hrlp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, codes and per-byte parse functions of the request-line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // result kinds
  localparam logic [2:0] KIND_METHOD = 3'd0;
  localparam logic [2:0] KIND_PATH   = 3'd1;
  localparam logic [2:0] KIND_KEY    = 3'd2;
  localparam logic [2:0] KIND_VALUE  = 3'd3;
  localparam logic [2:0] KIND_PAIR   = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  // status codes, lowest wins
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_EOL    = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_VERSION   = 3'd3;
  localparam logic [2:0] ST_TARGET    = 3'd4;
  localparam logic [2:0] ST_METHOD    = 3'd5;
  localparam logic [2:0] ST_PATH_ENC  = 3'd6;
  localparam logic [2:0] ST_QUERY_ENC = 3'd7;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  localparam logic [7:0] VERSION_TEXT [7] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e};

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_PATH,
    PH_KEY,
    PH_VALUE,
    PH_VERSION,
    PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic       cr_pending;
    logic [1:0] hex_seen;
    logic [3:0] hex_hi;
    logic       method_nonempty;
    logic       method_not_upper;
    logic       target_nonempty;
    logic       target_no_slash;
    logic [3:0] ver_len;
    logic       ver_mismatch;
    logic       path_bad;
    logic       query_bad;
    logic       pair_open;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_METHOD, cr_pending: 1'b0, hex_seen: 2'd0, hex_hi: 4'd0,
    method_nonempty: 1'b0, method_not_upper: 1'b0, target_nonempty: 1'b0,
    target_no_slash: 1'b0, ver_len: 4'd0, ver_mismatch: 1'b0,
    path_bad: 1'b0, query_bad: 1'b0, pair_open: 1'b0};

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] status;
  } result_t;

  typedef struct packed {
    parse_state_t st;
    logic         vld;
    result_t      res;
  } step_t;

  // one queue word: one or two results formed when one input byte is accepted
  typedef struct packed {
    result_t r0;
    logic    r1_vld;
    result_t r1;
  } entry_t;

  function automatic logic hex_ok(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61) v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  function automatic parse_state_t mark_bad(parse_state_t s, logic [2:0] kind);
    parse_state_t r;
    r = s;
    if (kind == KIND_PATH) r.path_bad = 1'b1;
    else r.query_bad = 1'b1;
    return r;
  endfunction

  function automatic parse_state_t end_segment(parse_state_t s, logic [2:0] kind);
    parse_state_t r;
    r = s;
    if (s.hex_seen != 2'd0) r = mark_bad(s, kind);
    r.hex_seen = 2'd0;
    return r;
  endfunction

  function automatic step_t no_result(parse_state_t s);
    step_t r;
    r.st  = s;
    r.vld = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic step_t enc_byte(parse_state_t s, logic [7:0] c, logic [2:0] kind);
    step_t      r;
    logic [7:0] d;
    r = no_result(s);
    d = {s.hex_hi, hex_nib(c)};
    case (s.hex_seen)
      2'd1: begin
        if (!hex_ok(c)) begin
          r.st          = mark_bad(s, kind);
          r.st.hex_seen = 2'd0;
        end else begin
          r.st.hex_hi   = hex_nib(c);
          r.st.hex_seen = 2'd2;
        end
      end
      2'd2: begin
        r.st.hex_seen = 2'd0;
        if (!hex_ok(c) || d == 8'h00) begin
          r.st          = mark_bad(s, kind);
          r.st.hex_seen = 2'd0;
        end else begin
          r.vld = 1'b1;
          r.res = '{kind: kind, data: d, status: ST_OK};
        end
      end
      default: begin
        if (c == CH_PCT) begin
          r.st.hex_seen = 2'd1;
        end else if (c == CH_PLUS) begin
          r.vld = 1'b1;
          r.res = '{kind: kind, data: CH_SPACE, status: ST_OK};
        end else if (c < CH_SPACE || c == CH_DEL) begin
          r.st = mark_bad(s, kind);
        end else begin
          r.vld = 1'b1;
          r.res = '{kind: kind, data: c, status: ST_OK};
        end
      end
    endcase
    return r;
  endfunction

  function automatic step_t close_query(parse_state_t s);
    step_t r;
    r = no_result(end_segment(s, KIND_KEY));
    if (s.pair_open) begin
      r.vld = 1'b1;
      r.res = '{kind: KIND_PAIR, data: 8'h00, status: ST_OK};
    end
    r.st.pair_open = 1'b0;
    return r;
  endfunction

  function automatic step_t line_byte(parse_state_t s, logic [7:0] c);
    step_t        r;
    parse_state_t t;
    r = no_result(s);
    t = s;
    unique case (s.phase)
      PH_METHOD: begin
        if (c == CH_SPACE) begin
          r.st.phase = PH_PATH;
        end else begin
          r.st.method_nonempty = 1'b1;
          if (c < 8'h41 || c > 8'h5a) r.st.method_not_upper = 1'b1;
          r.vld = 1'b1;
          r.res = '{kind: KIND_METHOD, data: c, status: ST_OK};
        end
      end
      PH_PATH: begin
        if (c == CH_SPACE) begin
          r.st       = end_segment(s, KIND_PATH);
          r.st.phase = PH_VERSION;
        end else begin
          if (!s.target_nonempty) begin
            t.target_nonempty = 1'b1;
            if (c != CH_SLASH) t.target_no_slash = 1'b1;
          end
          if (c == CH_QUERY) begin
            r.st       = end_segment(t, KIND_PATH);
            r.st.phase = PH_KEY;
          end else begin
            r = enc_byte(t, c, KIND_PATH);
          end
        end
      end
      PH_KEY: begin
        if (c == CH_SPACE) begin
          r          = close_query(s);
          r.st.phase = PH_VERSION;
        end else if (c == CH_AMP) begin
          r = close_query(s);
        end else begin
          t.pair_open = 1'b1;
          if (c == CH_EQ) begin
            r.st       = end_segment(t, KIND_KEY);
            r.st.phase = PH_VALUE;
          end else begin
            r = enc_byte(t, c, KIND_KEY);
          end
        end
      end
      PH_VALUE: begin
        if (c == CH_SPACE) begin
          r          = close_query(s);
          r.st.phase = PH_VERSION;
        end else if (c == CH_AMP) begin
          r          = close_query(s);
          r.st.phase = PH_KEY;
        end else begin
          r = enc_byte(s, c, KIND_VALUE);
        end
      end
      PH_VERSION: begin
        if (s.ver_len < 4'd7) begin
          if (c != VERSION_TEXT[s.ver_len[2:0]]) r.st.ver_mismatch = 1'b1;
        end else if (s.ver_len == 4'd7) begin
          if (c != CH_ZERO && c != CH_ONE) r.st.ver_mismatch = 1'b1;
        end else begin
          r.st.ver_mismatch = 1'b1;
        end
        if (s.ver_len < 4'd9) r.st.ver_len = s.ver_len + 4'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] line_status(parse_state_t s);
    if (s.phase != PH_VERSION) return ST_NO_SPACE;
    if (s.ver_len != 4'd8 || s.ver_mismatch) return ST_VERSION;
    if (!s.method_nonempty || !s.target_nonempty || s.target_no_slash) return ST_TARGET;
    if (s.method_not_upper) return ST_METHOD;
    if (s.path_bad) return ST_PATH_ENC;
    if (s.query_bad) return ST_QUERY_ENC;
    return ST_OK;
  endfunction

endpackage

// ----- rtl/hrlp_front.sv -----
// ----------------------------------------------------------------------------
// hrlp_front
// Takes one head byte per cycle while accept_i is high, tracks the parse
// state and forms the results of that byte (and of a held CR) as one queue word.
// ----------------------------------------------------------------------------
module hrlp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_head_i,
  output logic             wr_o,
  output hrlp_pkg::entry_t wdata_o
);
  import hrlp_pkg::*;

  parse_state_t st_q, st_d;
  step_t        a, b;
  result_t      r0, r1;
  logic         v0, v1, was_done, ended;

  always_comb begin
    st_d     = st_q;
    r0       = '0;
    r1       = '0;
    v0       = 1'b0;
    v1       = 1'b0;
    ended    = 1'b0;
    was_done = (st_q.phase == PH_DONE);
    a        = no_result(st_q);
    b        = no_result(st_q);
    if (!was_done) begin
      if (st_q.cr_pending) begin
        if (data_byte_i == CH_LF) begin
          v0               = 1'b1;
          r0               = '{kind: KIND_STATUS, data: 8'h00, status: line_status(st_q)};
          st_d.cr_pending  = 1'b0;
          st_d.phase       = PH_DONE;
          ended            = 1'b1;
        end else begin
          // the held CR is part of the line after all
          a    = line_byte(st_q, CH_CR);
          v0   = a.vld;
          r0   = a.res;
          st_d = a.st;
          if (data_byte_i != CH_CR) begin
            a.st.cr_pending = 1'b0;
            b    = line_byte(a.st, data_byte_i);
            v1   = b.vld;
            r1   = b.res;
            st_d = b.st;
          end
        end
      end else if (data_byte_i == CH_CR) begin
        st_d.cr_pending = 1'b1;
      end else begin
        a    = line_byte(st_q, data_byte_i);
        v0   = a.vld;
        r0   = a.res;
        st_d = a.st;
      end
    end
    if (end_of_head_i) begin
      if (!was_done && !ended) begin
        v0 = 1'b1;
        r0 = '{kind: KIND_STATUS, data: 8'h00, status: ST_NO_EOL};
        v1 = 1'b0;
      end
      st_d = STATE_RESET;
    end

    wr_o = accept_i && (v0 || v1);
    if (v0) begin
      wdata_o.r0     = r0;
      wdata_o.r1_vld = v1;
      wdata_o.r1     = r1;
    end else begin
      wdata_o.r0     = r1;
      wdata_o.r1_vld = 1'b0;
      wdata_o.r1     = r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ----- rtl/hrlp_fifo.sv -----
// ----------------------------------------------------------------------------
// hrlp_fifo
// Short register queue of result words between the front and back parts.
// ----------------------------------------------------------------------------
module hrlp_fifo #(
  parameter int unsigned DEPTH = hrlp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  hrlp_pkg::entry_t wdata_i,
  input  logic             rd_i,
  output hrlp_pkg::entry_t rdata_o,
  output logic             full_o,
  output logic             nempty_o
);
  import hrlp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o   = (cnt_q == CW'(DEPTH));
  assign nempty_o = (cnt_q != '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && nempty_o;
  assign rdata_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!do_wr && do_rd) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/hrlp_back.sv -----
// ----------------------------------------------------------------------------
// hrlp_back
// Unpacks queue words into single results and holds the oldest one on the
// result ports until it is popped.
// ----------------------------------------------------------------------------
module hrlp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             nempty_i,
  input  hrlp_pkg::entry_t rdata_i,
  output logic             rd_o,
  input  logic             pop,
  output logic             empty,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_o,
  output logic [2:0]       status_o,
  output logic             last_o
);
  import hrlp_pkg::*;

  result_t s0_q, s0_d, s1_q, s1_d;
  logic    v0_q, v0_d, v1_q, v1_d;
  logic    take;

  assign take = v0_q && pop;

  always_comb begin
    s0_d = s0_q;
    s1_d = s1_q;
    v0_d = v0_q;
    v1_d = v1_q;
    rd_o = 1'b0;
    if (take) begin
      s0_d = s1_q;
      v0_d = v1_q;
      v1_d = 1'b0;
    end
    // refill once the head slot is free and nothing waits behind it
    if (nempty_i && !v0_d) begin
      rd_o = 1'b1;
      s0_d = rdata_i.r0;
      v0_d = 1'b1;
      s1_d = rdata_i.r1;
      v1_d = rdata_i.r1_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign empty    = !v0_q;
  assign kind_o   = s0_q.kind;
  assign data_o   = s0_q.data;
  assign status_o = s0_q.status;
  assign last_o   = (s0_q.kind == KIND_STATUS);

endmodule

// ----- rtl/http_request_line_parser.sv -----
// ----------------------------------------------------------------------------
// http_request_line_parser
// Parses the request line of an HTTP head into decoded method, path, query
// key/value words, pair-end markers and one closing status word.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  -------   -----------------   ------------------------------------------
//  head in   push / full         data_byte_i, end_of_head_i
//  results   empty / pop         kind_o, data_o, status_o, last_o
//
//  One head byte is taken per cycle while full is low; a byte yields
//  zero, one or two words. Output drains one word per cycle while pop is
//  high, so the sustained input rate is set by the result port: two-word
//  bytes take two pops. The queue between the parser and the output stage
//  (QUEUE_DEPTH words) absorbs bursts. full rises only when that queue is
//  full; reset clears parse state and empties the queue, no clearing pass.
// ----------------------------------------------------------------------------
module http_request_line_parser #(
  parameter int unsigned QUEUE_DEPTH = hrlp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_head_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind_o,
  output logic [7:0] data_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import hrlp_pkg::*;

  logic   accept, wr, rd, nempty;
  entry_t wdata, rdata;

  assign accept = push && !full;

  hrlp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .end_of_head_i(end_of_head_i),
    .wr_o         (wr),
    .wdata_o      (wdata)
  );

  hrlp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (wdata),
    .rd_i    (rd),
    .rdata_o (rdata),
    .full_o  (full),
    .nempty_o(nempty)
  );

  hrlp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .nempty_i(nempty),
    .rdata_i (rdata),
    .rd_o    (rd),
    .pop     (pop),
    .empty   (empty),
    .kind_o  (kind_o),
    .data_o  (data_o),
    .status_o(status_o),
    .last_o  (last_o)
  );

endmodule

// ----- rtl/hrlp_checker.sv -----
// ----------------------------------------------------------------------------
// hrlp_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
module hrlp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [2:0] kind_o,
  input logic [7:0] data_o,
  input logic [2:0] status_o,
  input logic       last_o
);
  import hrlp_pkg::*;

  // a waiting word that is not popped stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(data_o) && $stable(status_o))
    else $error("result word changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (kind_o == KIND_STATUS)))
    else $error("last does not match status kind");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o != KIND_STATUS |-> status_o == ST_OK)
    else $error("status set on a data word");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == KIND_STATUS || kind_o == KIND_PAIR) |-> data_o == 8'h00)
    else $error("data set on a marker word");

  // a full queue stays full until a word is popped
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !pop |=> full)
    else $error("full dropped without a pop");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);
